>>> rtl/fbpa_pkg.sv
// shared constants, codes and control/status types of the block pool allocator
`default_nettype none

package fbpa_pkg;

    // pool geometry
    localparam int PAGE_W     = 4;
    localparam int SLOT_W     = 8;
    localparam int ID_W       = PAGE_W + SLOT_W;
    localparam int LINK_DEPTH = 1 << ID_W;
    localparam int SPP_W      = SLOT_W + 1;
    localparam int FREE_W     = 13;
    localparam int PAGES_W    = PAGE_W + 1;
    localparam int CAP_W      = PAGES_W + SPP_W;

    // field and register widths
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int ADDR_W     = 20;
    localparam int DSIZE_W    = 13;
    localparam int PSIZE_W    = 17;
    localparam int ALIGN_W    = 3;
    localparam int BB_W       = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int QUO_W      = PSIZE_W;
    localparam int CNT_W      = 5;

    // fixed pool constants
    localparam logic [PAGES_W-1:0] MAX_PAGES          = 5'd16;
    localparam logic [SPP_W-1:0]   MAX_BLOCKS_PER_PAGE = 9'd256;
    localparam logic [DSIZE_W-1:0] BLOCK_HEADER_BYTES = 13'd8;
    localparam logic [PSIZE_W-1:0] PAGE_HEADER_BYTES  = 17'd8;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE_ALL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_PAGES = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOTS = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2 = 2'd2;

    // reset values of registers and derived values
    localparam logic [DSIZE_W-1:0] RST_DATA_SIZE   = 13'd8;
    localparam logic [PSIZE_W-1:0] RST_PAGE_SIZE   = 17'd4096;
    localparam logic [ALIGN_W-1:0] RST_ALIGN_LOG2  = 3'd3;
    localparam logic [BB_W-1:0]    RST_BLOCK_BYTES = 14'd8;
    localparam logic [SPP_W-1:0]   RST_SLOTS       = 9'd256;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic mul;
        logic load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic cfg_hit;
        logic derive_busy;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/fixed_block_pool_allocator.sv
// top level of the fixed-size block pool allocator
// Requests come in on the s_axis channel: tuser carries the operation (allocate,
// free one block, free all), tdata the page and slot of a block to free. Each
// request gives exactly one result transfer on m_axis: status in tuser, and in
// tdata the allocated page, slot and byte address plus the free block count and
// pages in use after the request.
// A request passes capture, pool update, registered address multiply and result
// stage; its result is loaded once the output register is free, and the next
// request is taken only after that, as one request is in work at a time. The free
// list head link is read from the registered memory ahead of the update. A finished
// result waits in the output register while the next request is taken; a stalled
// receiver holds the block in its final stage once a second result is ready.
// Config writes (plain write port) must go in only while no request is in work;
// the block itself does not enforce it. A write to a listed index empties the pool
// and recomputes block size and slots per page (bit-serial divider, s_axis_tready low).
// Reset (synchronous, active low) restores the register defaults, empties the pool
// and leaves ready high on the next cycle; the link memory is not cleared.
`default_nettype none

module fixed_block_pool_allocator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // request channel
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [15:0]                       s_axis_tdata,  // page_index, slot_index
    input  wire logic [1:0]                        s_axis_tuser,  // mode
    // result channel
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // alloc_page, alloc_slot, byte_address, free_blocks, pages_in_use
    output logic [55:0]                            m_axis_tdata,
    output logic [1:0]                             m_axis_tuser   // status
);

    fbpa_pkg::t_cmd                    w_cmd;
    fbpa_pkg::t_stat                   w_stat;
    logic [fbpa_pkg::STATUS_W-1:0]     w_status;
    logic [fbpa_pkg::PAGE_W-1:0]       w_page;
    logic [fbpa_pkg::SLOT_W-1:0]       w_slot;
    logic [fbpa_pkg::ADDR_W-1:0]       w_addr;
    logic [fbpa_pkg::FREE_W-1:0]       w_free;
    logic [fbpa_pkg::PAGES_W-1:0]      w_pages;

    // sequencing
    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // pool state and arithmetic
    fbpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_mode      (s_axis_tuser),
        .i_page      (s_axis_tdata[3:0]),
        .i_slot      (s_axis_tdata[11:4]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_status    (w_status),
        .o_page      (w_page),
        .o_slot      (w_slot),
        .o_addr      (w_addr),
        .o_free      (w_free),
        .o_pages     (w_pages)
    );

    // result packing
    assign m_axis_tdata = {6'd0, w_pages, w_free, w_addr, w_slot, w_page};
    assign m_axis_tuser = w_status;

`ifndef ASSERT_OFF
    // one request in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    // status never carries the unused code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != fbpa_pkg::STATUS_BAD)
        else $error("result status out of range");

    // page count bounded by the pool
    a_pages_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[49:45] <= fbpa_pkg::MAX_PAGES)
        else $error("pages in use beyond pool size");

    // a result is only loaded while the request side is busy
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a request in work");
`endif

endmodule

`default_nettype wire

>>> rtl/fbpa_div.sv
// restoring divider, one quotient bit per cycle, for the slots-per-page value
`default_nettype none

module fbpa_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [fbpa_pkg::QUO_W-1:0]    i_dividend,
    input  wire logic [fbpa_pkg::BB_W-1:0]     i_divisor,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [fbpa_pkg::QUO_W-1:0]         o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [fbpa_pkg::CNT_W-1:0]    r_cnt;
    logic [fbpa_pkg::BB_W-1:0]     r_rem;
    logic [fbpa_pkg::BB_W-1:0]     r_dvs;
    logic [fbpa_pkg::QUO_W-1:0]    r_quo;

    logic [fbpa_pkg::BB_W:0]       w_trial;
    logic [fbpa_pkg::BB_W:0]       w_diff;
    logic                          w_fit;

    // one trial subtract per cycle
    assign w_trial = {r_rem, r_quo[fbpa_pkg::QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    // control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= fbpa_pkg::CNT_W'(fbpa_pkg::QUO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[fbpa_pkg::BB_W-1:0] : w_trial[fbpa_pkg::BB_W-1:0];
            r_quo <= {r_quo[fbpa_pkg::QUO_W-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

>>> rtl/fbpa_dp.sv
// datapath: config registers, derived sizes, free list memory, pool counters, result
`default_nettype none

module fbpa_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic [fbpa_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [fbpa_pkg::PAGE_W-1:0]       i_page,
    input  wire logic [fbpa_pkg::SLOT_W-1:0]       i_slot,
    input  wire fbpa_pkg::t_cmd                    i_cmd,
    output fbpa_pkg::t_stat                        o_stat,
    output logic [fbpa_pkg::STATUS_W-1:0]          o_status,
    output logic [fbpa_pkg::PAGE_W-1:0]            o_page,
    output logic [fbpa_pkg::SLOT_W-1:0]            o_slot,
    output logic [fbpa_pkg::ADDR_W-1:0]            o_addr,
    output logic [fbpa_pkg::FREE_W-1:0]            o_free,
    output logic [fbpa_pkg::PAGES_W-1:0]           o_pages
);

    // config registers and derived values
    logic [fbpa_pkg::DSIZE_W-1:0]  r_data_size;
    logic [fbpa_pkg::PSIZE_W-1:0]  r_page_size;
    logic [fbpa_pkg::ALIGN_W-1:0]  r_align;
    logic [fbpa_pkg::BB_W-1:0]     r_block_bytes;
    logic [fbpa_pkg::SPP_W-1:0]    r_slots;
    logic                          r_pend;

    // captured item
    logic [fbpa_pkg::MODE_W-1:0]   r_mode;
    logic [fbpa_pkg::PAGE_W-1:0]   r_pg;
    logic [fbpa_pkg::SLOT_W-1:0]   r_sl;

    // pool state
    logic [fbpa_pkg::ID_W-1:0]     r_head;
    logic [fbpa_pkg::PAGES_W-1:0]  r_pages;
    logic [fbpa_pkg::SPP_W-1:0]    r_fresh;
    logic [fbpa_pkg::FREE_W-1:0]   r_free;
    logic [fbpa_pkg::ID_W-1:0]     r_link_mem [fbpa_pkg::LINK_DEPTH];
    logic [fbpa_pkg::ID_W-1:0]     r_link_q;

    // per-item results
    logic                          r_got;
    logic [fbpa_pkg::STATUS_W-1:0] r_status;
    logic [fbpa_pkg::PAGE_W-1:0]   r_ap;
    logic [fbpa_pkg::SLOT_W-1:0]   r_as;
    logic [fbpa_pkg::ADDR_W-1:0]   r_prod_pg;
    logic [fbpa_pkg::ADDR_W-1:0]   r_prod_sl;

    // output register
    logic [fbpa_pkg::STATUS_W-1:0] r_o_status;
    logic [fbpa_pkg::PAGE_W-1:0]   r_o_page;
    logic [fbpa_pkg::SLOT_W-1:0]   r_o_slot;
    logic [fbpa_pkg::ADDR_W-1:0]   r_o_addr;
    logic [fbpa_pkg::FREE_W-1:0]   r_o_free;
    logic [fbpa_pkg::PAGES_W-1:0]  r_o_pages;

    // next values
    logic [fbpa_pkg::ID_W-1:0]     n_head;
    logic [fbpa_pkg::PAGES_W-1:0]  n_pages;
    logic [fbpa_pkg::SPP_W-1:0]    n_fresh;
    logic [fbpa_pkg::FREE_W-1:0]   n_free;
    logic                          n_got;
    logic [fbpa_pkg::STATUS_W-1:0] n_status;
    logic [fbpa_pkg::PAGE_W-1:0]   n_ap;
    logic [fbpa_pkg::SLOT_W-1:0]   n_as;

    logic                          w_cfg_hit;
    logic                          w_mem_we;
    logic [fbpa_pkg::ID_W-1:0]     w_free_id;
    logic [fbpa_pkg::DSIZE_W-1:0]  w_need;
    logic [fbpa_pkg::BB_W-1:0]     w_alm;
    logic [fbpa_pkg::BB_W-1:0]     w_bb;
    logic [fbpa_pkg::QUO_W-1:0]    w_dividend;
    logic                          w_div_busy;
    logic                          w_div_done;
    logic [fbpa_pkg::QUO_W-1:0]    w_quot;
    logic [fbpa_pkg::SPP_W-1:0]    w_slots_new;
    logic [fbpa_pkg::CAP_W-1:0]    w_cap;
    logic [fbpa_pkg::SPP_W-1:0]    w_fresh_start;
    logic                          w_free_ok;
    logic [fbpa_pkg::PSIZE_W+fbpa_pkg::PAGE_W-1:0] w_mul_pg;
    logic [fbpa_pkg::BB_W+fbpa_pkg::SLOT_W-1:0]    w_mul_sl;
    logic [fbpa_pkg::ADDR_W-1:0]   w_addr;

    // config write decode: indexes past the list are ignored
    assign w_cfg_hit = i_cfg_we && (i_cfg_index == fbpa_pkg::CFG_DATA_SIZE
                                 || i_cfg_index == fbpa_pkg::CFG_PAGE_SIZE
                                 || i_cfg_index == fbpa_pkg::CFG_ALIGN_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_size <= fbpa_pkg::RST_DATA_SIZE;
            r_page_size <= fbpa_pkg::RST_PAGE_SIZE;
            r_align     <= fbpa_pkg::RST_ALIGN_LOG2;
            r_pend      <= 1'b0;
        end else begin
            r_pend <= w_cfg_hit;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fbpa_pkg::CFG_DATA_SIZE:  r_data_size <= i_cfg_wdata[fbpa_pkg::DSIZE_W-1:0];
                    fbpa_pkg::CFG_PAGE_SIZE:  r_page_size <= i_cfg_wdata;
                    fbpa_pkg::CFG_ALIGN_LOG2: r_align     <= i_cfg_wdata[fbpa_pkg::ALIGN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // block size: header minimum, then round up to the alignment
    assign w_need = (r_data_size > fbpa_pkg::BLOCK_HEADER_BYTES)
                  ? r_data_size : fbpa_pkg::BLOCK_HEADER_BYTES;
    assign w_alm  = (fbpa_pkg::BB_W'(1) << r_align) - fbpa_pkg::BB_W'(1);
    assign w_bb   = ({1'b0, w_need} + w_alm) & ~w_alm;

    assign w_dividend = r_page_size - fbpa_pkg::PAGE_HEADER_BYTES;

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_pend),
        .i_dividend (w_dividend),
        .i_divisor  (w_bb),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // slots per page, clamped, zero when the header does not fit
    always_comb begin
        if (r_page_size < fbpa_pkg::PAGE_HEADER_BYTES) begin
            w_slots_new = '0;
        end else if (w_quot > fbpa_pkg::QUO_W'(fbpa_pkg::MAX_BLOCKS_PER_PAGE)) begin
            w_slots_new = fbpa_pkg::MAX_BLOCKS_PER_PAGE;
        end else begin
            w_slots_new = w_quot[fbpa_pkg::SPP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= fbpa_pkg::RST_BLOCK_BYTES;
            r_slots       <= fbpa_pkg::RST_SLOTS;
        end else begin
            if (r_pend) begin
                r_block_bytes <= w_bb;
            end
            if (w_div_done) begin
                r_slots <= w_slots_new;
            end
        end
    end

    assign o_stat.cfg_hit     = w_cfg_hit;
    assign o_stat.derive_busy = w_cfg_hit | r_pend | w_div_busy | w_div_done;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_pg   <= i_page;
            r_sl   <= i_slot;
        end
    end

    // free checks
    assign w_cap         = {{fbpa_pkg::SPP_W{1'b0}}, r_pages}
                         * {{fbpa_pkg::PAGES_W{1'b0}}, r_slots};
    assign w_fresh_start = r_slots - r_fresh;
    assign w_free_id     = {r_pg, r_sl};
    assign w_free_ok     = ({1'b0, r_pg} < r_pages)
                        && ({1'b0, r_sl} < r_slots)
                        && ({1'b0, r_free} < w_cap)
                        && !(({1'b0, r_pg} + 1'b1 == r_pages)
                             && ({1'b0, r_sl} >= w_fresh_start));

    // operation step
    always_comb begin
        n_head   = r_head;
        n_pages  = r_pages;
        n_fresh  = r_fresh;
        n_free   = r_free;
        n_got    = 1'b0;
        n_status = fbpa_pkg::STATUS_OK;
        n_ap     = '0;
        n_as     = '0;
        w_mem_we = 1'b0;
        case (r_mode)
            fbpa_pkg::MODE_ALLOC: begin
                if (r_slots == '0) begin
                    n_status = fbpa_pkg::STATUS_NO_SLOTS;
                end else if (r_free > {4'd0, r_fresh}) begin
                    // pop the free list
                    n_ap   = r_head[fbpa_pkg::ID_W-1:fbpa_pkg::SLOT_W];
                    n_as   = r_head[fbpa_pkg::SLOT_W-1:0];
                    n_head = r_link_q;
                    n_free = r_free - 1'b1;
                    n_got  = 1'b1;
                end else if (r_fresh != '0) begin
                    // next untouched slot of the newest page
                    n_ap    = fbpa_pkg::PAGE_W'(r_pages - 1'b1);
                    n_as    = w_fresh_start[fbpa_pkg::SLOT_W-1:0];
                    n_fresh = r_fresh - 1'b1;
                    n_free  = r_free - 1'b1;
                    n_got   = 1'b1;
                end else if (r_pages < fbpa_pkg::MAX_PAGES) begin
                    // open a new page
                    n_ap    = r_pages[fbpa_pkg::PAGE_W-1:0];
                    n_as    = '0;
                    n_pages = r_pages + 1'b1;
                    n_fresh = r_slots - 1'b1;
                    n_free  = r_free + {4'd0, n_fresh};
                    n_got   = 1'b1;
                end else begin
                    n_status = fbpa_pkg::STATUS_NO_PAGES;
                end
            end
            fbpa_pkg::MODE_FREE: begin
                if (w_free_ok) begin
                    w_mem_we = 1'b1;
                    n_head   = w_free_id;
                    n_free   = r_free + 1'b1;
                end
            end
            fbpa_pkg::MODE_FREE_ALL: begin
                n_head  = '0;
                n_pages = '0;
                n_fresh = '0;
                n_free  = '0;
            end
            default: ;
        endcase
    end

    // pool counters; a config write to a listed index empties the pool
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages <= '0;
            r_fresh <= '0;
            r_free  <= '0;
        end else if (w_cfg_hit) begin
            r_pages <= '0;
            r_fresh <= '0;
            r_free  <= '0;
        end else if (i_cmd.exec) begin
            r_pages <= n_pages;
            r_fresh <= n_fresh;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_head   <= n_head;
            r_got    <= n_got;
            r_status <= n_status;
            r_ap     <= n_ap;
            r_as     <= n_as;
        end
    end

    // link memory, head entry read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_mem_we) begin
            r_link_mem[w_free_id] <= r_head;
        end
        r_link_q <= r_link_mem[r_head];
    end

    // address products
    assign w_mul_pg = {{fbpa_pkg::PSIZE_W{1'b0}}, r_ap}
                    * {{fbpa_pkg::PAGE_W{1'b0}}, r_page_size};
    assign w_mul_sl = {{fbpa_pkg::BB_W{1'b0}}, r_as}
                    * {{fbpa_pkg::SLOT_W{1'b0}}, r_block_bytes};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_pg <= w_mul_pg[fbpa_pkg::ADDR_W-1:0];
            r_prod_sl <= w_mul_sl[fbpa_pkg::ADDR_W-1:0];
        end
    end

    assign w_addr = r_prod_pg + r_prod_sl
                  + fbpa_pkg::ADDR_W'(fbpa_pkg::PAGE_HEADER_BYTES);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_page   <= r_ap;
            r_o_slot   <= r_as;
            r_o_addr   <= r_got ? w_addr : '0;
            r_o_free   <= r_free;
            r_o_pages  <= r_pages;
        end
    end

    assign o_status = r_o_status;
    assign o_page   = r_o_page;
    assign o_slot   = r_o_slot;
    assign o_addr   = r_o_addr;
    assign o_free   = r_o_free;
    assign o_pages  = r_o_pages;

endmodule

`default_nettype wire

>>> rtl/fbpa_ctrl.sv
// controller state machine: item sequencing, size derivation wait, result handshake
`default_nettype none

module fbpa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    input  wire fbpa_pkg::t_stat   i_stat,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output fbpa_pkg::t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        ST_DERIVE = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_EXEC   = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_FIN    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.capture  = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.mul      = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            ST_DERIVE: begin
                if (!i_stat.derive_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_stat.cfg_hit) begin
                    n_state = ST_DERIVE;
                end else if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // no request transfer in a cycle with a config write
    assign o_in_ready  = (r_state == ST_IDLE) && !i_stat.cfg_hit;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> tb/tb_fixed_block_pool_allocator.sv
`timescale 1ns / 100ps
// self-checking testbench for the fixed block pool allocator: directed and random requests
module tb_fixed_block_pool_allocator;

    localparam int unsigned SLOT_SPAN   = fbpa_pkg::MAX_BLOCKS_PER_PAGE;
    localparam int unsigned PAGE_LIMIT  = fbpa_pkg::MAX_PAGES;
    localparam int unsigned BLK_HDR     = fbpa_pkg::BLOCK_HEADER_BYTES;
    localparam int unsigned PG_HDR      = fbpa_pkg::PAGE_HEADER_BYTES;
    localparam int unsigned IDLE_PCT    = 7;
    localparam int unsigned SHOW_LIMIT  = 10;
    localparam int unsigned STALL_LIMIT = 4000;

    typedef struct packed {
        logic [fbpa_pkg::MODE_W-1:0] mode;
        logic [fbpa_pkg::PAGE_W-1:0] page;
        logic [fbpa_pkg::SLOT_W-1:0] slot;
    } t_pool_req;

    typedef struct packed {
        logic [fbpa_pkg::STATUS_W-1:0] status;
        logic [fbpa_pkg::PAGE_W-1:0]   page;
        logic [fbpa_pkg::SLOT_W-1:0]   slot;
        logic [fbpa_pkg::ADDR_W-1:0]   addr;
        logic [fbpa_pkg::FREE_W-1:0]   free_n;
        logic [fbpa_pkg::PAGES_W-1:0]  pages;
    } t_pool_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata = '0;   // page_index, slot_index
    logic [1:0]                      s_axis_tuser = '0;   // mode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // alloc_page, alloc_slot, byte_address, free_blocks, pages_in_use
    logic [55:0]                     m_axis_tdata;
    logic [1:0]                      m_axis_tuser;        // status

    fixed_block_pool_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // pool model state and settings
    logic [fbpa_pkg::ID_W-1:0] link_mem [fbpa_pkg::LINK_DEPTH];
    logic [fbpa_pkg::ID_W-1:0] head_id;
    int unsigned     pages_open, fresh_left, free_count;
    int unsigned     block_bytes, slots_per_page;
    int unsigned     cfg_data, cfg_page, cfg_align;

    t_pool_req    pending_reqs[$];
    t_pool_result expected_results[$];

    int unsigned n_reqs, n_results, n_errors, n_settings;
    int unsigned n_granted, n_no_pages, n_no_slots, n_pushed;
    int unsigned stall_cycles;
    bit          req_taken;

    // block size and slots per page from the current registers
    function automatic void derive_geometry();
        int unsigned need, step;
        need = (cfg_data > BLK_HDR) ? cfg_data : BLK_HDR;
        step = 1 << cfg_align;
        block_bytes = (need + step - 1) & ~(step - 1);
        if (cfg_page < PG_HDR) begin
            slots_per_page = 0;
        end else begin
            slots_per_page = (cfg_page - PG_HDR) / block_bytes;
            if (slots_per_page > SLOT_SPAN) slots_per_page = SLOT_SPAN;
        end
    endfunction

    function automatic void empty_pool();
        head_id = '0;
        pages_open = 0;
        fresh_left = 0;
        free_count = 0;
    endfunction

    // one request against the pool: updates the model and returns the result
    function automatic t_pool_result apply_pool_request(t_pool_req r);
        t_pool_result res;
        int unsigned  pg_sel, sl_sel, id, byte_addr;
        bit           granted, legal;
        res = '0;
        granted = 1'b0;
        pg_sel = 0;
        sl_sel = 0;
        case (r.mode)
            fbpa_pkg::MODE_ALLOC: begin
                if (slots_per_page == 0) begin
                    res.status = fbpa_pkg::STATUS_NO_SLOTS;
                    n_no_slots++;
                end else if (free_count > fresh_left) begin
                    // pop the lifo free list
                    id = head_id;
                    pg_sel = id / SLOT_SPAN;
                    sl_sel = id % SLOT_SPAN;
                    head_id = link_mem[id[fbpa_pkg::ID_W-1:0]];
                    free_count--;
                    granted = 1'b1;
                end else if (fresh_left > 0) begin
                    // next untouched slot of the newest page
                    pg_sel = pages_open - 1;
                    sl_sel = slots_per_page - fresh_left;
                    fresh_left--;
                    free_count--;
                    granted = 1'b1;
                end else if (pages_open < PAGE_LIMIT) begin
                    pg_sel = pages_open;
                    sl_sel = 0;
                    pages_open++;
                    fresh_left = slots_per_page - 1;
                    free_count += slots_per_page - 1;
                    granted = 1'b1;
                end else begin
                    res.status = fbpa_pkg::STATUS_NO_PAGES;
                    n_no_pages++;
                end
                if (granted) begin
                    byte_addr = pg_sel * cfg_page + PG_HDR + sl_sel * block_bytes;
                    res.page = pg_sel[fbpa_pkg::PAGE_W-1:0];
                    res.slot = sl_sel[fbpa_pkg::SLOT_W-1:0];
                    res.addr = byte_addr[fbpa_pkg::ADDR_W-1:0];
                    n_granted++;
                end
            end
            fbpa_pkg::MODE_FREE: begin
                legal = (r.page < pages_open) && (r.slot < slots_per_page) &&
                        (free_count < pages_open * slots_per_page);
                // untouched slots of the newest page cannot be freed
                if (legal && r.page == pages_open - 1 && r.slot >= slots_per_page - fresh_left)
                    legal = 1'b0;
                if (legal) begin
                    id = r.page * SLOT_SPAN + r.slot;
                    link_mem[id[fbpa_pkg::ID_W-1:0]] = head_id;
                    head_id = id[fbpa_pkg::ID_W-1:0];
                    free_count++;
                    n_pushed++;
                end
            end
            fbpa_pkg::MODE_FREE_ALL: empty_pool();
            default: ;
        endcase
        res.free_n = free_count[fbpa_pkg::FREE_W-1:0];
        res.pages = pages_open[fbpa_pkg::PAGES_W-1:0];
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            n_errors++;
            if (n_errors <= SHOW_LIMIT)
                $display("result %0d %s: expected %0d, got %0d", n_results, name, want, seen);
        end
    endtask

    // request and result driver, idle cycles on both sides except in a quiet stretch
    always @(negedge i_clk) begin : req_driver
        t_pool_req nxt;
        bit        quiet;
        quiet = (n_reqs >= 600) && (n_reqs < 900);
        if (!s_axis_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (i_rst_n && pending_reqs.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0000, nxt.slot, nxt.page};
                s_axis_tuser <= nxt.mode;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor: predict on each request transfer, check each result transfer
    always @(posedge i_clk) begin : monitor
        t_pool_req    req;
        t_pool_result want;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            req.mode = s_axis_tuser;
            req.page = s_axis_tdata[3:0];
            req.slot = s_axis_tdata[11:4];
            expected_results.push_back(apply_pool_request(req));
            req_taken = 1'b1;
            n_reqs++;
            moved = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            moved = 1'b1;
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= SHOW_LIMIT)
                    $display("result %0d arrived with no request waiting for it", n_results);
            end else begin
                want = expected_results.pop_front();
                check_field("status", want.status, m_axis_tuser);
                check_field("alloc_page", want.page, m_axis_tdata[3:0]);
                check_field("alloc_slot", want.slot, m_axis_tdata[11:4]);
                check_field("byte_address", want.addr, m_axis_tdata[31:12]);
                check_field("free_blocks", want.free_n, m_axis_tdata[44:32]);
                check_field("pages_in_use", want.pages, m_axis_tdata[49:45]);
            end
        end
        // watchdog on cycles with no transfer at all
        if (moved)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("** fixed_block_pool_allocator: FAILED **");
            $finish;
        end
    end

    task automatic push_req(logic [fbpa_pkg::MODE_W-1:0] mode, int unsigned page,
                            int unsigned slot);
        t_pool_req r;
        r.mode = mode;
        r.page = page[fbpa_pkg::PAGE_W-1:0];
        r.slot = slot[fbpa_pkg::SLOT_W-1:0];
        pending_reqs.push_back(r);
    endtask

    // mostly allocations and frees of blocks likely handed out, plus noise
    task automatic queue_random(int unsigned count, int unsigned alloc_pct);
        int unsigned handed, done_n, roll, span;
        handed = 0;
        done_n = 0;
        while (done_n < count) begin
            roll = $urandom_range(0, 99);
            span = (slots_per_page == 0) ? 0 : handed / slots_per_page;
            if (span > PAGE_LIMIT - 1) span = PAGE_LIMIT - 1;
            if (roll < alloc_pct) begin
                push_req(fbpa_pkg::MODE_ALLOC, $urandom_range(0, 15), $urandom_range(0, 255));
                handed++;
                done_n++;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 80) begin
                    push_req(fbpa_pkg::MODE_FREE, $urandom_range(0, span),
                             (slots_per_page == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, slots_per_page - 1));
                    if (handed > 0) handed--;
                    done_n++;
                end else if (roll < 92) begin
                    push_req(fbpa_pkg::MODE_FREE, $urandom_range(0, 15),
                             $urandom_range(0, 255));
                    done_n++;
                end else if (roll < 96) begin
                    push_req(fbpa_pkg::MODE_NONE, $urandom_range(0, 15),
                             $urandom_range(0, 255));
                end else begin
                    push_req(fbpa_pkg::MODE_FREE_ALL, $urandom_range(0, 15),
                             $urandom_range(0, 255));
                    handed = 0;
                    done_n++;
                end
            end
        end
    endtask

    // wait until every request is sent and every result checked
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [fbpa_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val[fbpa_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            fbpa_pkg::CFG_DATA_SIZE:  cfg_data = val & 32'h1FFF;
            fbpa_pkg::CFG_PAGE_SIZE:  cfg_page = val & 32'h1FFFF;
            fbpa_pkg::CFG_ALIGN_LOG2: cfg_align = val & 32'h7;
            default: ;
        endcase
        derive_geometry();
        empty_pool();
        // the block recomputes its geometry with ready low
        @(posedge i_clk);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic set_pool(int unsigned data_sz, int unsigned page_sz, int unsigned align);
        write_reg(fbpa_pkg::CFG_DATA_SIZE, data_sz);
        write_reg(fbpa_pkg::CFG_PAGE_SIZE, page_sz);
        write_reg(fbpa_pkg::CFG_ALIGN_LOG2, align);
        n_settings++;
    endtask

    // stimulus sequence
    initial begin : stimulus
        int unsigned k;
        cfg_data = fbpa_pkg::RST_DATA_SIZE;
        cfg_page = fbpa_pkg::RST_PAGE_SIZE;
        cfg_align = fbpa_pkg::RST_ALIGN_LOG2;
        derive_geometry();
        empty_pool();
        n_settings = 1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);

        // reset settings: unknown mode, free of unopened page, untouched slot,
        // double free and lifo reuse of the same block
        push_req(fbpa_pkg::MODE_NONE, 15, 255);
        push_req(fbpa_pkg::MODE_FREE, 15, 255);
        push_req(fbpa_pkg::MODE_ALLOC, 0, 0);
        push_req(fbpa_pkg::MODE_ALLOC, 0, 0);
        push_req(fbpa_pkg::MODE_FREE, 0, 1);
        push_req(fbpa_pkg::MODE_FREE, 0, 200);
        push_req(fbpa_pkg::MODE_FREE, 0, 1);
        push_req(fbpa_pkg::MODE_ALLOC, 0, 0);
        push_req(fbpa_pkg::MODE_ALLOC, 0, 0);
        queue_random(200, 55);
        drain();

        // one slot per page: free with every block free, slot out of range, pool exhausted
        set_pool(1, 16, 0);
        push_req(fbpa_pkg::MODE_ALLOC, 0, 0);
        push_req(fbpa_pkg::MODE_FREE, 0, 0);
        push_req(fbpa_pkg::MODE_FREE, 0, 0);
        push_req(fbpa_pkg::MODE_FREE, 0, 1);
        for (k = 0; k < 17; k++) push_req(fbpa_pkg::MODE_ALLOC, 0, 0);
        queue_random(150, 60);
        drain();

        // largest registers, 128-byte alignment, addresses wrap
        set_pool(8191, 131071, 7);
        queue_random(200, 90);
        drain();

        // zero blocks per page, with the page header larger than the page next
        set_pool(4096, 8, 2);
        push_req(fbpa_pkg::MODE_ALLOC, 0, 0);
        queue_random(20, 50);
        drain();
        set_pool(0, 0, 5);
        queue_random(10, 50);
        drain();

        // smallest data size with many slots clamped
        set_pool(0, 65536, 6);
        queue_random(150, 55);
        drain();

        for (k = 0; k < 6; k++) begin
            set_pool($urandom_range(1, 300), $urandom_range(16, 1200), $urandom_range(0, 6));
            queue_random(100, 55);
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("covered %0d requests over %0d pool settings: %0d blocks handed out, %0d %s",
                 n_reqs, n_settings, n_granted, n_pushed, "frees pushed");
        $display("%0d out-of-pages and %0d zero-slot refusals, %0d results checked, %0d %s",
                 n_no_pages, n_no_slots, n_results, n_errors, "mismatches");
        if (n_errors == 0)
            $display("** fixed_block_pool_allocator: PASSED **");
        else
            $display("** fixed_block_pool_allocator: FAILED **");
        $finish;
    end

endmodule
